>>> sv/assert_macros.svh
// assertion macros used by the checker in ovca_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define OVCA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ovca assertion failed");

// next-cycle implication, disabled while reset is high
`define OVCA_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ovca assertion failed");

`endif

>>> sv/ovca_pkg.sv
// shared types and constants of the output vc credit allocator
// no dependencies
package ovca_pkg;

   localparam int CMD_W  = 2;
   localparam int VNET_W = 2;
   localparam int VC_W   = 4;

   localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CREDIT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEND   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

   typedef struct packed {
      logic capture;
      logic execute;
      logic report;
   } ovca_ctrl_type;

endpackage

>>> sv/ovca_ctrl.sv
// sequencer of the output vc credit allocator: handshakes and step commands
// depends on ovca_pkg
module ovca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output ovca_pkg::ovca_ctrl_type ctrl
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_STAT = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_STAT;
         end
         ST_STAT: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = (state_ff == ST_SEND);
   assign ctrl.capture = req_tvalid && req_tready;
   assign ctrl.execute = (state_ff == ST_EXEC);
   assign ctrl.report  = (state_ff == ST_STAT);

endmodule

>>> sv/ovca_dpath.sv
// datapath of the output vc credit allocator: vc flags, credit counters, result
// depends on ovca_pkg
module ovca_dpath #(
   parameter int NUM_VNETS      = 4,
   parameter int VCS_PER_VNET   = 4,
   parameter int BUFFERS_PER_VC = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ovca_pkg::ovca_ctrl_type       ctrl,
   input  logic [ovca_pkg::CMD_W-1:0]    cmd,
   input  logic [ovca_pkg::VNET_W-1:0]   vnet,
   input  logic [ovca_pkg::VC_W-1:0]     vc,
   input  logic                          free_signal,
   output logic                          granted,
   output logic [ovca_pkg::VC_W-1:0]     granted_vc,
   output logic                          vc_has_credit,
   output logic                          vnet_has_free,
   output logic                          credit_error
);

   localparam int TOTAL_VCS = NUM_VNETS * VCS_PER_VNET;
   localparam int IDX_W     = (TOTAL_VCS > 1) ? $clog2(TOTAL_VCS) : 1;
   localparam int SUM_W     = IDX_W + 5;
   localparam int PICK_W    = (VCS_PER_VNET > 1) ? $clog2(VCS_PER_VNET) : 1;
   localparam int CR_DEPTH  = (TOTAL_VCS < 16) ? TOTAL_VCS : 16;
   localparam int CR_W      = (CR_DEPTH > 1) ? $clog2(CR_DEPTH) : 1;
   localparam int CW        = $clog2(BUFFERS_PER_VC + 1);

   // latched item
   logic [ovca_pkg::CMD_W-1:0]  cmd_ff;
   logic [ovca_pkg::VNET_W-1:0] vnet_ff;
   logic [ovca_pkg::VC_W-1:0]   vc_ff;
   logic                        fsig_ff;

   // vc state
   logic [TOTAL_VCS-1:0] active_ff;
   logic [TOTAL_VCS-1:0] active_in;
   logic [CW-1:0]        credits_ff [CR_DEPTH];
   logic [CW-1:0]        credits_in [CR_DEPTH];

   // result
   logic                         granted_ff;
   logic                         granted_in;
   logic [ovca_pkg::VC_W-1:0]    gvc_ff;
   logic [ovca_pkg::VC_W-1:0]    gvc_in;
   logic                         err_ff;
   logic                         err_in;
   logic                         hascr_ff;
   logic                         hasfree_ff;

   logic [SUM_W-1:0]        vc_wide;
   logic [SUM_W-1:0]        base_wide;
   logic [SUM_W-1:0]        gsum;
   logic                    vc_ok;
   logic                    vnet_ok;
   logic [IDX_W-1:0]        vidx;
   logic [CR_W-1:0]         cidx;
   logic [IDX_W-1:0]        base;
   logic [VCS_PER_VNET-1:0] grp;
   logic                    found;
   logic [PICK_W-1:0]       pick;
   logic [CW-1:0]           cr;

   assign vc_wide   = SUM_W'(vc_ff);
   assign vc_ok     = vc_wide < SUM_W'(TOTAL_VCS);
   assign vidx      = vc_wide[IDX_W-1:0];
   assign cidx      = vc_wide[CR_W-1:0];
   assign vnet_ok   = SUM_W'(vnet_ff) < SUM_W'(NUM_VNETS);
   assign base_wide = SUM_W'(vnet_ff) * SUM_W'(VCS_PER_VNET);
   assign base      = vnet_ok ? base_wide[IDX_W-1:0] : '0;
   assign grp       = active_ff[base +: VCS_PER_VNET];
   assign cr        = vc_ok ? credits_ff[cidx] : '0;

   // lowest idle vc of the group
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int i = VCS_PER_VNET - 1; i >= 0; i--) begin
         if (!grp[i]) begin
            found = 1'b1;
            pick  = PICK_W'(i);
         end
      end
   end

   assign gsum = SUM_W'(base) + SUM_W'(pick);

   always_comb begin
      active_in  = active_ff;
      credits_in = credits_ff;
      granted_in = 1'b0;
      gvc_in     = '0;
      err_in     = 1'b0;
      unique case (cmd_ff)
         ovca_pkg::CMD_ALLOC: begin
            if (vnet_ok && found) begin
               active_in[gsum[IDX_W-1:0]] = 1'b1;
               granted_in                 = 1'b1;
               gvc_in                     = gsum[ovca_pkg::VC_W-1:0];
            end
         end
         ovca_pkg::CMD_CREDIT: begin
            if (vc_ok) begin
               if (cr >= CW'(BUFFERS_PER_VC)) begin
                  err_in = 1'b1;
               end else begin
                  credits_in[cidx] = cr + CW'(1);
               end
               if (fsig_ff) begin
                  active_in[vidx] = 1'b0;
               end
            end
         end
         ovca_pkg::CMD_SEND: begin
            if (vc_ok) begin
               if (cr == '0) begin
                  err_in = 1'b1;
               end else begin
                  credits_in[cidx] = cr - CW'(1);
               end
            end
         end
         ovca_pkg::CMD_QUERY: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff  <= cmd;
         vnet_ff <= vnet;
         vc_ff   <= vc;
         fsig_ff <= free_signal;
      end
      if (ctrl.execute) begin
         granted_ff <= granted_in;
         gvc_ff     <= gvc_in;
         err_ff     <= err_in;
      end
      if (ctrl.report) begin
         hascr_ff   <= vc_ok && (cr != '0);
         hasfree_ff <= vnet_ok && !(&grp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < CR_DEPTH; i++) begin
            credits_ff[i] <= CW'(BUFFERS_PER_VC);
         end
      end else if (ctrl.execute) begin
         active_ff  <= active_in;
         credits_ff <= credits_in;
      end
   end

   assign granted       = granted_ff;
   assign granted_vc    = gvc_ff;
   assign vc_has_credit = hascr_ff;
   assign vnet_has_free = hasfree_ff;
   assign credit_error  = err_ff;

endmodule

>>> sv/output_vc_credit_allocator.sv
// Output-port vc tracker with credit flow control. One item is worked at a
// time. After an item is accepted, the sequencer in ovca_ctrl steps through
// the state update (EXEC) and the status lookup (STAT), then offers the
// result on rsp until the sink takes it. A new item is taken only once the
// sequencer is back in idle, after the last result has left. A stalled sink
// holds the sequencer, and with it the input. State is in flip-flops and is
// ready straight after reset.
// depends on ovca_pkg, ovca_ctrl, ovca_dpath
module output_vc_credit_allocator #(
   parameter int NUM_VNETS      = 4,
   parameter int VCS_PER_VNET   = 4,
   parameter int BUFFERS_PER_VC = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // vnet[1:0], vc[5:2], free_signal[6], zero[7]
   input  logic [1:0] req_tuser,   // cmd[1:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // granted[0], granted_vc[4:1], vc_has_credit[5],
                                   // vnet_has_free[6], credit_error[7]
);

   ovca_pkg::ovca_ctrl_type ctrl;

   logic                        granted;
   logic [ovca_pkg::VC_W-1:0]   granted_vc;
   logic                        vc_has_credit;
   logic                        vnet_has_free;
   logic                        credit_error;

   ovca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   ovca_dpath #(
      .NUM_VNETS      (NUM_VNETS),
      .VCS_PER_VNET   (VCS_PER_VNET),
      .BUFFERS_PER_VC (BUFFERS_PER_VC)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .cmd           (req_tuser),
      .vnet          (req_tdata[1:0]),
      .vc            (req_tdata[5:2]),
      .free_signal   (req_tdata[6]),
      .granted       (granted),
      .granted_vc    (granted_vc),
      .vc_has_credit (vc_has_credit),
      .vnet_has_free (vnet_has_free),
      .credit_error  (credit_error)
   );

   assign rsp_tdata = {credit_error, vnet_has_free, vc_has_credit, granted_vc, granted};

endmodule

>>> sv/ovca_checker.sv
// port-level checks of the output vc credit allocator, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module ovca_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   logic rsp_wait;

   assign rsp_wait = rsp_tvalid && !rsp_tready;

   // a waiting result holds
   `OVCA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata))

   // one item in flight
   `OVCA_ASSERT_NXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)

   `OVCA_ASSERT_IMP(a_no_take_on_rsp, clock, reset, rsp_tvalid, !req_tready)

   // no grant means vc index zero
   `OVCA_ASSERT_IMP(a_gvc_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[4:1] == 4'd0)

   // a grant and a credit error never come together
   `OVCA_ASSERT_IMP(a_grant_no_err, clock, reset, rsp_tvalid && rsp_tdata[0], !rsp_tdata[7])

endmodule

bind output_vc_credit_allocator ovca_checker u_ovca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> sim/output_vc_credit_allocator_tb.sv
// testbench for output_vc_credit_allocator: directed and random commands with a
// built-in predictor of vc state and credits, checked item by item on rsp
// depends on ovca_pkg and output_vc_credit_allocator
`timescale 1ns / 100ps

module output_vc_credit_allocator_tb;

   localparam int NUM_VNETS      = 4;
   localparam int VCS_PER_VNET   = 4;
   localparam int BUFFERS_PER_VC = 4;
   localparam int TOTAL_VCS      = NUM_VNETS * VCS_PER_VNET;
   localparam int HOLD_OFF_CYCLES = 80;

   // last member lands in the lowest bit, matching rsp_tdata
   typedef struct packed {
      logic       credit_error;
      logic       vnet_has_free;
      logic       vc_has_credit;
      logic [3:0] granted_vc;
      logic       granted;
   } vc_status_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;   // vnet[1:0], vc[5:2], free_signal[6], zero[7]
   logic [1:0] req_tuser;   // cmd[1:0]
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;   // granted[0], granted_vc[4:1], vc_has_credit[5],
                            // vnet_has_free[6], credit_error[7]

   logic       vc_busy [TOTAL_VCS];
   logic [2:0] vc_credit_count [TOTAL_VCS];
   vc_status_type expected_status [$];
   int mismatch_count = 0;
   int burst_left = 0;
   int hold_off_asked = 0;
   int hold_off_served = 0;

   output_vc_credit_allocator #(
      .NUM_VNETS(NUM_VNETS),
      .VCS_PER_VNET(VCS_PER_VNET),
      .BUFFERS_PER_VC(BUFFERS_PER_VC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic vnet_has_idle_vc(input logic [1:0] vnet);
      int i;
      if (vnet >= NUM_VNETS) return 1'b0;
      for (i = 0; i < VCS_PER_VNET; i++)
         if (!vc_busy[vnet * VCS_PER_VNET + i]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic vc_status_type track_vc_command(input logic [1:0] cmd,
         input logic [1:0] vnet, input logic [3:0] vc, input logic free_signal);
      vc_status_type s;
      logic vc_ok;
      int base;
      int i;
      s = '0;
      vc_ok = (vc < TOTAL_VCS);
      case (cmd)
         ovca_pkg::CMD_ALLOC: begin
            if (vnet < NUM_VNETS) begin
               base = vnet * VCS_PER_VNET;
               for (i = 0; i < VCS_PER_VNET; i++) begin
                  if (!s.granted && !vc_busy[base + i]) begin
                     vc_busy[base + i] = 1'b1;
                     s.granted = 1'b1;
                     s.granted_vc = 4'(base + i);
                  end
               end
            end
         end
         ovca_pkg::CMD_CREDIT: begin
            if (vc_ok) begin
               if (vc_credit_count[vc] >= BUFFERS_PER_VC) s.credit_error = 1'b1;
               else vc_credit_count[vc] = vc_credit_count[vc] + 3'd1;
               if (free_signal) vc_busy[vc] = 1'b0;
            end
         end
         ovca_pkg::CMD_SEND: begin
            if (vc_ok) begin
               if (vc_credit_count[vc] == 3'd0) s.credit_error = 1'b1;
               else vc_credit_count[vc] = vc_credit_count[vc] - 3'd1;
            end
         end
         default: ;
      endcase
      s.vc_has_credit = vc_ok && (vc_credit_count[vc] != 3'd0);
      s.vnet_has_free = vnet_has_idle_vc(vnet);
      return s;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s, got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // result check first, then prediction for an item accepted at the same edge
   always @(posedge clock) begin
      vc_status_type got;
      vc_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = vc_status_type'(rsp_tdata);
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected item", int'(rsp_tdata), 0);
         end else begin
            want = expected_status.pop_front();
            if (got.granted !== want.granted)
               report_mismatch("granted", int'(got.granted), int'(want.granted));
            if (got.granted_vc !== want.granted_vc)
               report_mismatch("granted_vc", int'(got.granted_vc), int'(want.granted_vc));
            if (got.vc_has_credit !== want.vc_has_credit)
               report_mismatch("vc_has_credit", int'(got.vc_has_credit),
                  int'(want.vc_has_credit));
            if (got.vnet_has_free !== want.vnet_has_free)
               report_mismatch("vnet_has_free", int'(got.vnet_has_free),
                  int'(want.vnet_has_free));
            if (got.credit_error !== want.credit_error)
               report_mismatch("credit_error", int'(got.credit_error),
                  int'(want.credit_error));
         end
      end
      if (!reset && req_tvalid && req_tready)
         expected_status.insert(expected_status.size(),
            track_vc_command(req_tuser, req_tdata[1:0], req_tdata[5:2], req_tdata[6]));
   end

   // sink side: stall patterns, plus long hold-offs on request
   initial begin
      int hold_left;
      int pattern_left;
      int phase;
      logic [15:0] stall_pattern;
      hold_left = 0;
      pattern_left = 0;
      phase = 0;
      stall_pattern = '1;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_served != hold_off_asked) begin
            hold_off_served++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern_left = $urandom_range(16, 96);
               case ($urandom_range(0, 3))
                  0: stall_pattern = '1;
                  1: stall_pattern = 16'($urandom);
                  2: stall_pattern = 16'($urandom | $urandom);
                  default: stall_pattern = 16'($urandom & $urandom);
               endcase
               stall_pattern[0] = 1'b1;
            end
            pattern_left--;
            rsp_tready <= stall_pattern[phase];
            phase = (phase + 1) % 16;
         end
      end
   end

   // sends one item in bursts with random gaps, returns at the accepting edge
   task automatic issue_command(input logic [1:0] cmd, input logic [1:0] vnet,
         input logic [3:0] vc, input logic free_signal);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(5, 16);
            default: gap = $urandom_range(1, 4);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {1'b0, free_signal, vc, vnet};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic test_allocate_exhaust();
      int i;
      for (i = 0; i < VCS_PER_VNET + 1; i++)
         issue_command(ovca_pkg::CMD_ALLOC, 2'd3, 4'(i * 3), 1'(i));
      issue_command(ovca_pkg::CMD_ALLOC, 2'd0, 4'd15, 1'b1);
   endtask

   task automatic test_credit_limits();
      int i;
      // drain vc 15 to zero and one beyond
      for (i = 0; i < BUFFERS_PER_VC + 1; i++)
         issue_command(ovca_pkg::CMD_SEND, 2'd3, 4'd15, 1'b0);
      // send on an idle vc, then give the credit back
      issue_command(ovca_pkg::CMD_SEND, 2'd1, 4'd5, 1'b1);
      issue_command(ovca_pkg::CMD_CREDIT, 2'd1, 4'd5, 1'b0);
      // return at full count still frees the vc
      issue_command(ovca_pkg::CMD_CREDIT, 2'd0, 4'd0, 1'b1);
      issue_command(ovca_pkg::CMD_CREDIT, 2'd3, 4'd15, 1'b0);
      issue_command(ovca_pkg::CMD_CREDIT, 2'd3, 4'd15, 1'b1);
   endtask

   task automatic test_query();
      issue_command(ovca_pkg::CMD_QUERY, 2'd3, 4'd15, 1'b1);
      issue_command(ovca_pkg::CMD_QUERY, 2'd0, 4'd0, 1'b0);
      issue_command(ovca_pkg::CMD_QUERY, 2'd2, 4'd10, 1'b0);
   endtask

   task automatic test_receiver_hold_off();
      int i;
      hold_off_asked++;
      burst_left = 40;
      for (i = 0; i < 24; i++)
         issue_command(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
            4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_packet_flows(input int item_count);
      int issued;
      int flits;
      int k;
      logic [1:0] vnet;
      logic [3:0] vc;
      issued = 0;
      while (issued < item_count) begin
         vnet = 2'($urandom_range(0, NUM_VNETS - 1));
         issue_command(ovca_pkg::CMD_ALLOC, vnet, 4'($urandom_range(0, 15)),
            1'($urandom_range(0, 1)));
         issued++;
         vc = 4'(vnet * VCS_PER_VNET + $urandom_range(0, VCS_PER_VNET - 1));
         flits = $urandom_range(1, BUFFERS_PER_VC + 2);
         for (k = 0; k < flits; k++) begin
            if ($urandom_range(0, 5) == 0) begin
               issue_command(ovca_pkg::CMD_QUERY, 2'($urandom_range(0, 3)), vc,
                  1'($urandom_range(0, 1)));
               issued++;
            end
            issue_command(ovca_pkg::CMD_SEND, 2'($urandom_range(0, 3)), vc,
               1'($urandom_range(0, 1)));
            issued++;
         end
         for (k = 0; k < flits; k++) begin
            issue_command(ovca_pkg::CMD_CREDIT, vnet, vc,
               (k == flits - 1) || ($urandom_range(0, 7) == 0));
            issued++;
         end
      end
   endtask

   task automatic test_random_commands(input int item_count);
      int i;
      for (i = 0; i < item_count; i++)
         issue_command(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
            4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int i;
      int waited;
      for (i = 0; i < TOTAL_VCS; i++) begin
         vc_busy[i] = 1'b0;
         vc_credit_count[i] = 3'(BUFFERS_PER_VC);
      end
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= ovca_pkg::CMD_QUERY;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_allocate_exhaust();
      test_credit_limits();
      test_query();
      test_receiver_hold_off();
      test_packet_flows(1200);
      test_random_commands(800);

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_status.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_status.size() != 0)
         report_mismatch("items never returned", expected_status.size(), 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
